// ===== rtl/prk_pkg.sv =====
// Package for the permutation rank/unrank unit.
// Holds field widths, the factorial table and the pipeline stage record.
// No dependencies.
package prk_pkg;

    localparam int NIB_W   = 4;
    localparam int NUM_POS = 15;
    localparam int PERM_W  = NUM_POS * NIB_W;
    localparam int RANK_W  = 41;
    localparam int SIZE_W  = 4;

    localparam int                MAX_ENTRIES_DEF = 15;
    localparam logic [SIZE_W-1:0] PERM_SIZE_RST   = 4'd12;

    localparam logic ACT_RANK   = 1'b0;
    localparam logic ACT_UNRANK = 1'b1;

    // k! for k = 0 .. 15, all below 2**41
    localparam logic [RANK_W-1:0] FACT [16] = '{
        41'd1, 41'd1, 41'd2, 41'd6, 41'd24, 41'd120, 41'd720, 41'd5040,
        41'd40320, 41'd362880, 41'd3628800, 41'd39916800, 41'd479001600,
        41'd6227020800, 41'd87178291200, 41'd1307674368000
    };

    typedef struct packed {
        logic                valid;
        logic                action;
        logic                err;
        logic [SIZE_W-1:0]   n;
        logic [RANK_W-1:0]   acc;
        logic [PERM_W-1:0]   perm;
        logic [NUM_POS-1:0]  used;
    } t_stage;

endpackage

// ===== rtl/prk_cell.sv =====
// One cell of the rank/unrank chain: handles the position whose weight is J!.
// Depends on prk_pkg.
module prk_cell
    import prk_pkg::*;
#(
    parameter int J = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    localparam logic [RANK_W-1:0] F = FACT[J];

    t_stage              r_stage;
    t_stage              n_stage;
    logic                active;
    logic [SIZE_W-1:0]   pos;
    logic [NIB_W-1:0]    r;
    logic [NUM_POS-1:0]  lt;
    logic [NIB_W-1:0]    m;
    logic [NIB_W:0]      diff;
    logic [NIB_W:0]      diff_neg;
    logic [NIB_W-1:0]    mag;
    logic [RANK_W-1:0]   prod;
    logic [RANK_W-1:0]   term;
    logic [NUM_POS-1:0]  ge;
    logic [NIB_W-1:0]    digit;
    logic [RANK_W-1:0]   sub;
    logic [NUM_POS-1:0]  free;
    logic [NUM_POS-1:0]  hit;
    logic [NIB_W-1:0]    pick;

    assign active = (i_stage.n > SIZE_W'(J));
    assign pos    = i_stage.n - SIZE_W'(J + 1);
    assign free   = ~i_stage.used;

    // rank side: entry at pos, smaller entries to its left, weighted by J!
    always_comb begin
        r = '0;
        for (int k = 0; k < NUM_POS; k++) begin
            if (SIZE_W'(k) == pos) begin
                r = i_stage.perm[k*NIB_W +: NIB_W];
            end
        end
        for (int k = 0; k < NUM_POS; k++) begin
            lt[k] = (SIZE_W'(k) < pos) && (i_stage.perm[k*NIB_W +: NIB_W] < r);
        end
        m        = NIB_W'($countones(lt));
        diff     = {1'b0, r} - {1'b0, m};
        diff_neg = -diff;
        mag      = diff[NIB_W] ? diff_neg[NIB_W-1:0] : diff[NIB_W-1:0];
        prod     = F * RANK_W'(mag);
        term     = diff[NIB_W] ? -prod : prod;
    end

    // unrank side: factorial digit by compare against constant multiples
    always_comb begin
        ge = '0;
        for (int k = 1; k < NUM_POS; k++) begin
            if (k <= J) begin
                ge[k] = (i_stage.acc >= F * RANK_W'(k));
            end
        end
        digit = NIB_W'($countones(ge));
        sub   = F * RANK_W'(digit);
        for (int v = 0; v < NUM_POS; v++) begin
            hit[v] = free[v] && (NIB_W'($countones(free & ((NUM_POS'(1) << v) - NUM_POS'(1))))
                     == digit);
        end
        // lowest hit wins; no hit picks zero
        pick = '0;
        for (int v = NUM_POS - 1; v >= 0; v--) begin
            if (hit[v]) begin
                pick = NIB_W'(v);
            end
        end
    end

    always_comb begin
        n_stage = i_stage;
        if (active) begin
            if (i_stage.action == ACT_UNRANK) begin
                n_stage.acc = i_stage.acc - sub;
                for (int k = 0; k < NUM_POS; k++) begin
                    if (SIZE_W'(k) == pos) begin
                        n_stage.perm[k*NIB_W +: NIB_W] = pick;
                    end
                end
                n_stage.used[pick] = 1'b1;
            end else if (J > 0) begin
                n_stage.acc = i_stage.acc + term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/permutation_rank_unrank_unit.sv =====
// Permutation rank/unrank unit: top level with input stage, cell chain and output stage.
// Depends on prk_pkg and prk_cell.
//
// Usage:
//   Drive i_action, i_perm_in and i_rank_in with i_start high; the item is
//   taken at that edge because o_busy stays low. One item can be started
//   every cycle. Action rank returns o_rank_out; action unrank returns
//   o_perm_out, or o_range_error with zeros when the rank is not below n!.
//   n is perm_size, capped at the cell count min(MAX_ENTRIES, 15).
//   Each item passes one input stage, one cell per position and one
//   output stage, each registered; o_done rises with the result.
//   Throughput is one item per cycle, set by the cell chain.
//   Each result stands for exactly one cycle; the receiver cannot stall,
//   so nothing is held back inside.
//   perm_size is written with i_cfg_we / i_cfg_wdata; the user must write
//   it only while no item is in flight, which the block does not enforce.
//   Synchronous reset sets perm_size to 12 and drops all items in flight.
module permutation_rank_unrank_unit
    import prk_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_action,
    input  logic [PERM_W-1:0] i_perm_in,
    input  logic [RANK_W-1:0] i_rank_in,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_done,
    output logic [RANK_W-1:0] o_rank_out,
    output logic [PERM_W-1:0] o_perm_out,
    output logic              o_range_error
);

    localparam int CELLS = (MAX_ENTRIES < NUM_POS) ? MAX_ENTRIES : NUM_POS;

    logic [SIZE_W-1:0] r_perm_size;
    logic [SIZE_W-1:0] n_eff;
    t_stage            n_in;
    t_stage            r_in_stage;
    t_stage            s [CELLS+1];
    t_stage            s_last;
    logic              r_done;
    logic              r_range_error;
    logic [RANK_W-1:0] r_rank_out;
    logic [PERM_W-1:0] r_perm_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_size <= PERM_SIZE_RST;
        end else if (i_cfg_we) begin
            r_perm_size <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;
    assign n_eff  = (r_perm_size > SIZE_W'(CELLS)) ? SIZE_W'(CELLS) : r_perm_size;

    // input stage: latch size, range check, seed accumulator
    always_comb begin
        n_in.valid  = i_start;
        n_in.action = i_action;
        n_in.n      = n_eff;
        n_in.used   = '0;
        if (i_action == ACT_UNRANK) begin
            n_in.err  = (i_rank_in >= FACT[n_eff]);
            n_in.acc  = i_rank_in;
            n_in.perm = '0;
        end else begin
            n_in.err  = 1'b0;
            n_in.acc  = '0;
            n_in.perm = i_perm_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stage <= '0;
        end else begin
            r_in_stage <= n_in;
        end
    end

    assign s[0] = r_in_stage;

    // first cell carries the largest factorial weight
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        prk_cell #(
            .J(CELLS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (s[g]),
            .o_stage (s[g+1])
        );
    end

    assign s_last = s[CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= 1'b0;
            r_range_error <= 1'b0;
        end else begin
            r_done        <= s_last.valid;
            r_range_error <= s_last.valid && s_last.action && s_last.err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank_out <= (s_last.action == ACT_UNRANK) ? '0 : s_last.acc;
        r_perm_out <= (s_last.action == ACT_UNRANK && !s_last.err) ? s_last.perm : '0;
    end

    assign o_done        = r_done;
    assign o_range_error = r_range_error;
    assign o_rank_out    = r_rank_out;
    assign o_perm_out    = r_perm_out;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(CELLS + 2) o_done)
        else $error("result strobe missing after accepted item");

    a_err_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_error |-> (o_done && o_perm_out == '0 && o_rank_out == '0))
        else $error("range error without strobe or with nonzero payload");

    a_one_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rank_out == '0 || o_perm_out == '0))
        else $error("rank and permutation both nonzero");
`endif

endmodule
